// ===== rtl/guttman_transform_update_defines.svh =====
// Assertion macros for the Guttman transform block.
// Used by the controller and datapath modules; no other dependencies.
`ifndef GUTTMAN_TRANSFORM_UPDATE_DEFINES_SVH
`define GUTTMAN_TRANSFORM_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
`define GTU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GTU_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define GTU_ASSERT(lbl, clk, rst_n, prop, msg)
`define GTU_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/gtu_pkg.sv =====
// Shared types, constants and helpers of the Guttman transform block.
// No dependencies.
package gtu_pkg;
  localparam int MaxObjects = 32;
  localparam int MaxDims    = 2;
  localparam int PairDepth  = (MaxObjects * (MaxObjects - 1)) / 2;
  localparam int ObjW       = $clog2(MaxObjects);
  localparam int PairW      = $clog2(PairDepth);
  localparam int CoordDepth = MaxObjects * MaxDims;
  localparam int CoordW     = $clog2(CoordDepth);
  localparam int QW         = 64;
  localparam logic signed [63:0] AccLimit = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_COORD = 2'd0,
    CMD_PAIR  = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_RELAX = 2'd0,
    CFG_NOBJ  = 2'd1,
    CFG_NDIM  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_RDW, ST_TERM, ST_DIV, ST_ACC,
    ST_FIN, ST_FDIV, ST_FWR, ST_EMIT, ST_EWAIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic              wr_coord;
    logic              wr_pair;
    logic              rd;
    logic              term;
    logic              div_start;
    logic              acc_clr;
    logic              acc_add;
    logic              fin;
    logic              fdiv_start;
    logic              buf_wr;
    logic              emit_load;
    logic [ObjW-1:0]   i;
    logic [ObjW-1:0]   j;
    logic              dim;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic div_busy;
    logic skip;
  } sts_t;

  // triangular pair slot
  function automatic logic [PairW-1:0] pair_slot(input logic [ObjW-1:0] a,
                                                 input logic [ObjW-1:0] b);
    logic [ObjW-1:0] hi, lo;
    logic [2*ObjW-1:0] tri_num;
    hi  = (a > b) ? a : b;
    lo  = (a > b) ? b : a;
    tri_num = ({{ObjW{1'b0}}, hi} * ({{ObjW{1'b0}}, hi} - (2*ObjW)'(1))) >> 1;
    return PairW'(tri_num + {{ObjW{1'b0}}, lo});
  endfunction
endpackage

// ===== rtl/gtu_divider.sv =====
// Radix-2 restoring unsigned divider, 64-bit dividend, one bit per cycle.
// Depends on gtu_pkg.
module gtu_divider (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [gtu_pkg::QW-1:0] dividend,
  input  logic [gtu_pkg::QW-1:0] divisor,
  output logic                   busy,
  output logic [gtu_pkg::QW-1:0] quotient
);
  localparam int CntW = $clog2(gtu_pkg::QW + 1);
  logic [CntW-1:0]         cnt_r, cnt_nxt;
  logic [gtu_pkg::QW-1:0]  q_r, q_nxt, rem_r, rem_nxt, dvs_r;
  logic [gtu_pkg::QW:0]    trial;

  // start load, or one shift-subtract step while busy
  always_comb begin
    trial   = {rem_r, q_r[gtu_pkg::QW-1]} - {1'b0, dvs_r};
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = CntW'(gtu_pkg::QW);
      q_nxt   = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!trial[gtu_pkg::QW]) begin
        rem_nxt = trial[gtu_pkg::QW-1:0];
        q_nxt   = {q_r[gtu_pkg::QW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[gtu_pkg::QW-2:0], q_r[gtu_pkg::QW-1]};
        q_nxt   = {q_r[gtu_pkg::QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = q_r;
endmodule

// ===== rtl/gtu_datapath.sv =====
// Datapath: stores, term multiply, shared divider, accumulator, output register.
// Depends on gtu_pkg, gtu_divider and the assertion header.
`include "guttman_transform_update_defines.svh"
module gtu_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gtu_pkg::ctl_t               ctl,
  output gtu_pkg::sts_t               sts,
  input  logic [gtu_pkg::ObjW-1:0]    in_obj,
  input  logic [gtu_pkg::ObjW-1:0]    in_other,
  input  logic                        in_dim,
  input  logic [31:0]                 in_coord,
  input  logic [30:0]                 in_dissim,
  input  logic [30:0]                 in_dist,
  input  logic                        relax,
  input  logic [5:0]                  n_obj,
  output logic [31:0]                 res_coord
);
  logic [31:0] coord_mem [gtu_pkg::CoordDepth];
  logic [30:0] dis_mem   [gtu_pkg::PairDepth];
  logic [30:0] dst_mem   [gtu_pkg::PairDepth];
  logic [31:0] upd_mem   [gtu_pkg::MaxObjects];

  logic [31:0] xi_r, xj_r, res_r;
  logic [30:0] dis_r, dst_r;
  logic [63:0] prod_r;
  logic        neg_r, fneg_r;
  logic signed [63:0] acc_r, fin_sum;
  logic [gtu_pkg::PairW-1:0]  wslot, rslot;
  logic [gtu_pkg::CoordW-1:0] ci, cj, cw;
  logic signed [32:0] diff;
  logic [32:0] mag;
  logic        div_start, div_busy;
  logic [63:0] div_a, div_b, div_q, qsat;
  logic signed [64:0] tsum, tsum_c;
  logic signed [63:0] fres;
  logic signed [65:0] fval;

  assign wslot = gtu_pkg::pair_slot(in_obj, in_other);
  assign rslot = gtu_pkg::pair_slot(ctl.i, ctl.j);
  assign ci    = {ctl.i, ctl.dim};
  assign cj    = {ctl.j, ctl.dim};
  assign cw    = {in_obj, in_dim};

  // stores: written by load items and by result emit, read by the run sequencer
  always_ff @(posedge clk) begin
    if (ctl.wr_coord) begin
      coord_mem[cw] <= in_coord;
    end else if (ctl.emit_load) begin
      coord_mem[ci] <= upd_mem[ctl.i];
    end
    if (ctl.wr_pair) begin
      dis_mem[wslot] <= in_dissim;
      dst_mem[wslot] <= in_dist;
    end
    if (ctl.rd) begin
      xi_r  <= coord_mem[ci];
      dis_r <= dis_mem[rslot];
      dst_r <= dst_mem[rslot];
    end
    if (ctl.term) begin
      xj_r <= coord_mem[cj];
    end
    if (ctl.buf_wr) begin
      upd_mem[ctl.i] <= res_r;
    end
    if (ctl.emit_load) begin
      res_coord <= upd_mem[ctl.i];
    end
  end

  // magnitude of the coordinate difference; sign kept for the accumulate
  assign diff = $signed({xi_r[31], xi_r}) - $signed({xj_r[31], xj_r});
  assign mag  = diff[32] ? 33'(-diff) : 33'(diff);
  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      neg_r <= diff[32];
    end
  end

  // final sum scaling: (2*acc or acc) over n, sign handled outside divider
  assign fin_sum = relax ? (acc_r <<< 1) : acc_r;
  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      prod_r <= fin_sum[63] ? 64'(-fin_sum) : 64'(fin_sum);
      fneg_r <= fin_sum[63];
    end
  end

  assign div_start = ctl.div_start | ctl.fdiv_start;
  assign div_a     = ctl.div_start ? ({31'b0, mag} * {33'b0, dis_r}) : prod_r;
  assign div_b     = ctl.div_start ? {33'b0, dst_r} : {58'b0, n_obj};

  gtu_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // clamp term and accumulate with saturation
  assign qsat   = (div_q > 64'(gtu_pkg::AccLimit)) ? 64'(gtu_pkg::AccLimit) : div_q;
  assign tsum   = 65'(acc_r) + (neg_r ? -65'($signed(qsat)) : 65'($signed(qsat)));
  assign tsum_c = (tsum > 65'(gtu_pkg::AccLimit)) ? 65'(gtu_pkg::AccLimit) :
                  (tsum < -65'(gtu_pkg::AccLimit)) ? -65'(gtu_pkg::AccLimit) : tsum;
  always_ff @(posedge clk) begin
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (ctl.acc_add) begin
      acc_r <= 64'(tsum_c);
    end
  end

  // final result: signed quotient, minus old coordinate when relaxing, saturate
  assign fres = fneg_r ? -$signed(div_q) : $signed(div_q);
  assign fval = 66'(fres) - (relax ? 66'($signed(xi_r)) : 66'sd0);
  assign res_r = (fval > 66'sd2147483647) ? 32'h7FFF_FFFF :
                 (fval < -66'sd2147483648) ? 32'h8000_0000 : fval[31:0];

  assign sts.div_busy = div_busy;
  assign sts.skip     = (dst_r == '0);

  `GTU_ASSERT(a_no_dual_start, clk, rst_n, !(ctl.div_start && ctl.fdiv_start), "dual start")
  `GTU_ASSERT_NEXT(a_div_busy, clk, rst_n, div_start, div_busy, "divider not busy")
  `GTU_ASSERT(a_no_start_busy, clk, rst_n, !(div_start && div_busy), "start while busy")
endmodule

// ===== rtl/gtu_ctrl.sv =====
// Controller: command decode and run sequencer over dimensions, objects, pairs.
// Depends on gtu_pkg and the assertion header.
`include "guttman_transform_update_defines.svh"
module gtu_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_cmd,
  input  logic [gtu_pkg::ObjW-1:0] in_obj,
  input  logic [gtu_pkg::ObjW-1:0] in_other,
  input  logic [5:0]               n_obj,
  input  logic                     n_dim2,
  input  gtu_pkg::sts_t            sts,
  output gtu_pkg::ctl_t            ctl,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [gtu_pkg::ObjW-1:0] out_obj,
  output logic                     out_dim,
  output logic                     out_last
);
  gtu_pkg::state_t st_r, st_nxt;
  logic [gtu_pkg::ObjW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic d_r, d_nxt, ov_r, ov_nxt, last_r, last_nxt;
  logic acc_in, i_end, j_end;
  logic [gtu_pkg::ObjW-1:0] nm1;
  logic sts_add_r, fstart_r;

  assign nm1    = 5'(n_obj - 6'd1);
  assign i_end  = (i_r == nm1);
  assign j_end  = (j_r == nm1);
  assign acc_in = in_valid && in_ready;
  assign in_ready = (st_r == gtu_pkg::ST_IDLE) && !ov_r;

  // next state
  always_comb begin
    st_nxt = st_r; i_nxt = i_r; j_nxt = j_r; d_nxt = d_r;
    ov_nxt = ov_r && !out_ready; last_nxt = last_r;
    unique case (st_r)
      gtu_pkg::ST_IDLE: begin
        if (acc_in && in_cmd == gtu_pkg::CMD_RUN) begin
          st_nxt = gtu_pkg::ST_RD; i_nxt = '0; j_nxt = '0; d_nxt = 1'b0;
        end
      end
      gtu_pkg::ST_RD: begin
        st_nxt = (j_r == i_r) ? gtu_pkg::ST_ACC : gtu_pkg::ST_RDW;
      end
      gtu_pkg::ST_RDW: st_nxt = sts.skip ? gtu_pkg::ST_ACC : gtu_pkg::ST_TERM;
      gtu_pkg::ST_TERM: st_nxt = gtu_pkg::ST_DIV;
      gtu_pkg::ST_DIV: if (!sts.div_busy) st_nxt = gtu_pkg::ST_ACC;
      gtu_pkg::ST_ACC: begin
        if (j_end) begin
          st_nxt = gtu_pkg::ST_FIN; j_nxt = '0;
        end else begin
          st_nxt = gtu_pkg::ST_RD; j_nxt = j_r + 1'b1;
        end
      end
      gtu_pkg::ST_FIN: st_nxt = gtu_pkg::ST_FDIV;
      // divide starts in the first cycle here, so wait for it to run
      gtu_pkg::ST_FDIV: if (!sts.div_busy && !fstart_r) st_nxt = gtu_pkg::ST_FWR;
      gtu_pkg::ST_FWR: begin
        if (i_end) begin
          st_nxt = gtu_pkg::ST_EMIT; i_nxt = '0;
        end else begin
          st_nxt = gtu_pkg::ST_RD; i_nxt = i_r + 1'b1;
        end
      end
      gtu_pkg::ST_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          last_nxt = i_end && (d_r || !n_dim2);
          if (!i_end) begin
            i_nxt = i_r + 1'b1;
          end else if (!d_r && n_dim2) begin
            st_nxt = gtu_pkg::ST_RD; i_nxt = '0; d_nxt = 1'b1;
          end else begin
            st_nxt = gtu_pkg::ST_IDLE;
          end
        end
      end
      default: st_nxt = gtu_pkg::ST_IDLE;
    endcase
  end

  // outputs: xj is read in RDW so the term divide in TERM sees it
  always_comb begin
    ctl = '0;
    ctl.i = i_r; ctl.j = j_r; ctl.dim = d_r;
    ctl.wr_coord = acc_in && in_cmd == gtu_pkg::CMD_COORD;
    ctl.wr_pair  = acc_in && in_cmd == gtu_pkg::CMD_PAIR && in_obj != in_other;
    unique case (st_r)
      gtu_pkg::ST_RD:   begin
        ctl.rd = 1'b1;
        ctl.acc_clr = (j_r == '0);
      end
      gtu_pkg::ST_RDW:  ctl.term = 1'b1;
      gtu_pkg::ST_TERM: ctl.div_start = 1'b1;
      gtu_pkg::ST_ACC:  ctl.acc_add = sts_add_r;
      gtu_pkg::ST_FIN:  begin ctl.fin = 1'b1; ctl.rd = 1'b1; ctl.j = i_r; end
      gtu_pkg::ST_FDIV: ctl.fdiv_start = fstart_r;
      gtu_pkg::ST_FWR:  ctl.buf_wr = 1'b1;
      gtu_pkg::ST_EMIT: ctl.emit_load = !ov_r || out_ready;
      default: ;
    endcase
  end

  // state, term-valid and final-start flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= gtu_pkg::ST_IDLE; ov_r <= 1'b0; last_r <= 1'b0;
      sts_add_r <= 1'b0; fstart_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; last_r <= last_nxt;
      if (st_r == gtu_pkg::ST_TERM) sts_add_r <= 1'b1;
      else if (st_r == gtu_pkg::ST_ACC) sts_add_r <= 1'b0;
      fstart_r <= (st_r == gtu_pkg::ST_FIN);
    end
    i_r <= i_nxt; j_r <= j_nxt; d_r <= d_nxt;
    if (ctl.emit_load) begin
      out_obj <= i_r; out_dim <= d_r;
    end
  end

  assign out_valid = ov_r;
  assign out_last  = last_r;

  `GTU_ASSERT(a_ready_idle, clk, rst_n, !in_ready || st_r == gtu_pkg::ST_IDLE, "ready off idle")
  `GTU_ASSERT_NEXT(a_last_idle, clk, rst_n, ov_r && last_r && out_ready,
                   !ov_r || !last_r || st_r == gtu_pkg::ST_IDLE, "last not at end")
  `GTU_ASSERT(a_no_pair_self, clk, rst_n, !ctl.wr_pair || in_obj != in_other, "self pair")
endmodule

// ===== rtl/guttman_transform_update.sv =====
// Top level of the SMACOF Guttman transform engine.
// Depends on gtu_pkg, gtu_ctrl, gtu_datapath.
//
// Input channel in_*: one item per handshake. command 0 writes a coordinate,
// 1 writes a pair dissimilarity and distance, 2 runs one Guttman transform.
// Load items are stored when taken. A run item is followed by n*p result items
// on out_*, dimension 0 objects 0..n-1, then dimension 1, tlast on the final.
// Each pair term waits on one 64-bit restoring divide (one quotient bit per
// cycle) in the single shared divider; a skipped pair (zero distance) and
// the diagonal bypass the divide. Each object adds a final divide by n.
// No new item is taken while a run is active or a result waits.
// Reset (rst_n low, synchronous) clears control and sets the registers to
// relax 0, 32 objects, 2 dimensions; stores are undefined until written.
// When out_tready is low the current result holds and further results wait.
// Configuration is written through cfg_we, cfg_index, cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
module guttman_transform_update (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] command, [6:2] obj_index, [11:7] other_index, [12] dim_index,
  // [44:13] coord_value, [75:45] dissim_value, [106:76] dist_value, zero fill
  input  logic [111:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] out_object, [5] out_dimension, [37:6] new_coord, zero fill
  output logic [39:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_wdata
);
  logic       relax_r;
  logic [5:0] nobj_r, n_eff;
  logic [1:0] ndim_r;
  gtu_pkg::ctl_t ctl;
  gtu_pkg::sts_t sts;
  logic [4:0]  o_obj;
  logic        o_dim;
  logic [31:0] o_coord;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relax_r <= 1'b0; nobj_r <= 6'd32; ndim_r <= 2'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        gtu_pkg::CFG_RELAX: relax_r <= cfg_wdata[0];
        gtu_pkg::CFG_NOBJ:  nobj_r  <= cfg_wdata;
        gtu_pkg::CFG_NDIM:  ndim_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end
  assign n_eff = (nobj_r < 6'd2) ? 6'd2 : (nobj_r > 6'd32) ? 6'd32 : nobj_r;

  gtu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_cmd(in_tdata[1:0]), .in_obj(in_tdata[6:2]), .in_other(in_tdata[11:7]),
    .n_obj(n_eff), .n_dim2(ndim_r[1]), .sts(sts), .ctl(ctl),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_obj(o_obj),
    .out_dim(o_dim), .out_last(out_tlast)
  );

  gtu_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_obj(in_tdata[6:2]), .in_other(in_tdata[11:7]), .in_dim(in_tdata[12]),
    .in_coord(in_tdata[44:13]), .in_dissim(in_tdata[75:45]),
    .in_dist(in_tdata[106:76]), .relax(relax_r), .n_obj(n_eff),
    .res_coord(o_coord)
  );

  assign out_tdata = {2'b0, o_coord, o_dim, o_obj};
endmodule
